[hw/rtl/sfr_pkg.sv]
// Shared types and constants for the stuffed frame receiver.
// Used by stuffed_frame_receiver, its checker and its testbench; depends on nothing.
package sfr_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_CODE_RST    = 8'hBA;
    localparam logic [BYTE_W-1:0] END_CODE_RST      = 8'hDA;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST   = 8'hFA;
    localparam logic [BYTE_W-1:0] UNESCAPE_MASK_RST = 8'hFA;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNESCAPE_MASK = 2'd3;

    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_LEN  = 2'd1,
        PHASE_BODY = 2'd2
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PASS = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2,
        KIND_DROP = 2'd3
    } kind_t;

endpackage

[hw/rtl/stuffed_frame_receiver.sv]
// Decoder for length-prefixed, byte-stuffed frames: top level.
// Depends on sfr_pkg for the phase and result-kind types and register codes.
//
// Accepts one received byte per clock and produces at most one result per
// byte, in the cycle after acceptance, from a single output register. A new byte
// is taken in every cycle as long as the output register is empty or its
// transaction completes in that same cycle, so the sustained rate is one byte
// per cycle; the only limit is that single output register waiting on m_ready.
// Outside a frame, bytes other than the start code pass through (kind 0). The
// start code opens a frame and the byte after it is the payload length, taken
// as is. In the body each payload byte is delivered at once with its position
// (kind 1); the escape code makes the next byte payload, ANDed with the
// unescape mask. Once the length is reached, the end code completes the frame
// (kind 2, with its length) and any other byte drops it (kind 3). A raw start
// code mid-body drops the frame and opens a new one; a raw end code mid-body
// drops it. Escape detection takes priority over the start and end codes.
// Write the four code registers only while the block is idle.
module stuffed_frame_receiver
    import sfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_rx_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [KIND_W-1:0]    m_kind,
    output logic [BYTE_W-1:0]    m_data_byte,
    output logic [BYTE_W-1:0]    m_position,
    output logic [BYTE_W-1:0]    m_frame_length
);

    // Code registers
    logic [BYTE_W-1:0] start_code_reg;
    logic [BYTE_W-1:0] end_code_reg;
    logic [BYTE_W-1:0] escape_code_reg;
    logic [BYTE_W-1:0] unescape_mask_reg;

    // Frame state
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic              escape_reg, escape_next;

    // Result of the byte on the input this cycle
    logic              res_valid;
    kind_t             res_kind;
    logic [BYTE_W-1:0] res_data;
    logic [BYTE_W-1:0] res_pos;
    logic [BYTE_W-1:0] res_len;

    // Output register
    logic              m_valid_reg;
    kind_t             m_kind_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic [BYTE_W-1:0] m_pos_reg;
    logic [BYTE_W-1:0] m_len_reg;

    logic in_accept;

    // Take a byte whenever the output slot is free or is being emptied now
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg    <= START_CODE_RST;
            end_code_reg      <= END_CODE_RST;
            escape_code_reg   <= ESCAPE_CODE_RST;
            unescape_mask_reg <= UNESCAPE_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_START_CODE:    start_code_reg    <= cfg_wdata;
                CFG_END_CODE:      end_code_reg      <= cfg_wdata;
                CFG_ESCAPE_CODE:   escape_code_reg   <= cfg_wdata;
                CFG_UNESCAPE_MASK: unescape_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // State register: advance only on an accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PHASE_IDLE;
            count_reg  <= '0;
            length_reg <= '0;
            escape_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            escape_reg <= escape_next;
        end
    end

    // Next state and result for the byte presented on the input
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        length_next = length_reg;
        escape_next = escape_reg;
        res_valid   = 1'b0;
        res_kind    = KIND_PASS;
        res_data    = '0;
        res_pos     = '0;
        res_len     = '0;

        case (phase_reg)
            PHASE_LEN: begin
                // Length byte: store it whatever its value
                length_next = s_rx_byte;
                count_next  = '0;
                escape_next = 1'b0;
                phase_next  = PHASE_BODY;
            end

            PHASE_BODY: begin
                if (count_reg == length_reg) begin
                    // Count reached: only the end code completes the frame
                    phase_next  = PHASE_IDLE;
                    escape_next = 1'b0;
                    res_valid   = 1'b1;
                    if (s_rx_byte == end_code_reg) begin
                        res_kind = KIND_DONE;
                        res_len  = length_reg;
                    end else begin
                        res_kind = KIND_DROP;
                    end
                end else if (escape_reg) begin
                    escape_next = 1'b0;
                    count_next  = count_reg + 1'b1;
                    res_valid   = 1'b1;
                    res_kind    = KIND_DATA;
                    res_data    = s_rx_byte & unescape_mask_reg;
                    res_pos     = count_reg;
                end else if (s_rx_byte == escape_code_reg) begin
                    escape_next = 1'b1;
                end else if (s_rx_byte == start_code_reg) begin
                    // Restart: drop the partial frame, await a new length
                    phase_next = PHASE_LEN;
                    res_valid  = 1'b1;
                    res_kind   = KIND_DROP;
                end else if (s_rx_byte == end_code_reg || count_reg > length_reg) begin
                    phase_next = PHASE_IDLE;
                    res_valid  = 1'b1;
                    res_kind   = KIND_DROP;
                end else begin
                    count_next = count_reg + 1'b1;
                    res_valid  = 1'b1;
                    res_kind   = KIND_DATA;
                    res_data   = s_rx_byte;
                    res_pos    = count_reg;
                end
            end

            default: begin
                // Idle, and any unused phase code
                if (s_rx_byte == start_code_reg) begin
                    phase_next = PHASE_LEN;
                end else begin
                    phase_next = PHASE_IDLE;
                    res_valid  = 1'b1;
                    res_kind   = KIND_PASS;
                    res_data   = s_rx_byte;
                end
            end
        endcase
    end

    // Output register: load on accept, drop the valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            m_kind_reg <= res_kind;
            m_data_reg <= res_data;
            m_pos_reg  <= res_pos;
            m_len_reg  <= res_len;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_data_byte    = m_data_reg;
    assign m_position     = m_pos_reg;
    assign m_frame_length = m_len_reg;

endmodule

[hw/rtl/stuffed_frame_receiver_checker.sv]
// Port-level checks for stuffed_frame_receiver, attached by bind.
// Depends on sfr_pkg for the result-kind codes.
module stuffed_frame_receiver_checker
    import sfr_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIND_W-1:0] m_kind,
    input logic [BYTE_W-1:0] m_data_byte,
    input logic [BYTE_W-1:0] m_position,
    input logic [BYTE_W-1:0] m_frame_length
);

    // Hold a stalled result transaction unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data_byte)
            && $stable(m_position) && $stable(m_frame_length))
        else $error("result changed while stalled");

    // Input stalls only behind a full, stalled output register
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_DONE || m_kind == KIND_DROP) |-> m_data_byte == '0)
        else $error("data byte not zero on frame event");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_DATA |-> m_position == '0)
        else $error("position not zero outside payload");

    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_DONE |-> m_frame_length == '0)
        else $error("frame length not zero outside completion");

endmodule

bind stuffed_frame_receiver stuffed_frame_receiver_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_data_byte    (m_data_byte),
    .m_position     (m_position),
    .m_frame_length (m_frame_length)
);

[dv/tb_stuffed_frame_receiver.sv]
`timescale 1ns / 100ps
// Self-checking testbench for stuffed_frame_receiver: directed and random byte streams
// with a built-in frame decoder model and a result scoreboard. Depends on sfr_pkg and stuffed_frame_receiver.
module tb_stuffed_frame_receiver;
    import sfr_pkg::*;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] pos;
        logic [BYTE_W-1:0] len;
    } decoded_t;

    // Block interface; every input starts at a known value
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_START_CODE;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [KIND_W-1:0]    m_kind;
    logic [BYTE_W-1:0]    m_data_byte;
    logic [BYTE_W-1:0]    m_position;
    logic [BYTE_W-1:0]    m_frame_length;

    // Mirror of the code registers
    logic [BYTE_W-1:0] code_start;
    logic [BYTE_W-1:0] code_end;
    logic [BYTE_W-1:0] code_esc;
    logic [BYTE_W-1:0] code_mask;

    // Decoder state as the block should hold it
    phase_t            dec_phase;
    logic [BYTE_W-1:0] dec_count;
    logic [BYTE_W-1:0] dec_len;
    bit                dec_esc;

    decoded_t pending_decodes[$];
    int       bytes_sent  = 0;
    int       mismatches  = 0;
    int       tx_run_left = 0;   // transactions left in a back-to-back run on the sender side
    int       rx_run_left = 0;   // same for the receiver side

    stuffed_frame_receiver uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_data_byte    (m_data_byte),
        .m_position     (m_position),
        .m_frame_length (m_frame_length)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Work out what one accepted byte should produce and queue it
    function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
        decoded_t r;
        bit       hit;
        r.kind = KIND_PASS;
        r.data = '0;
        r.pos  = '0;
        r.len  = '0;
        hit    = 1'b1;
        if (dec_phase == PHASE_LEN) begin
            // length byte: any value, codes included
            dec_len   = b;
            dec_count = '0;
            dec_esc   = 1'b0;
            dec_phase = PHASE_BODY;
            hit       = 1'b0;
        end else if (dec_phase != PHASE_BODY) begin
            dec_phase = PHASE_IDLE;
            if (b == code_start) begin
                dec_phase = PHASE_LEN;
                hit       = 1'b0;
            end else begin
                r.data = b;
            end
        end else if (dec_count == dec_len) begin
            // count reached: only the end code completes, anything else drops
            dec_phase = PHASE_IDLE;
            dec_esc   = 1'b0;
            if (b == code_end) begin
                r.kind = KIND_DONE;
                r.len  = dec_len;
            end else begin
                r.kind = KIND_DROP;
            end
        end else if (dec_esc) begin
            dec_esc   = 1'b0;
            r.kind    = KIND_DATA;
            r.data    = b & code_mask;
            r.pos     = dec_count;
            dec_count = dec_count + 1'b1;
        end else if (b == code_esc) begin
            // escape beats start and end when the codes coincide
            dec_esc = 1'b1;
            hit     = 1'b0;
        end else if (b == code_start) begin
            dec_phase = PHASE_LEN;
            r.kind    = KIND_DROP;
        end else if (b == code_end || dec_count > dec_len) begin
            dec_phase = PHASE_IDLE;
            r.kind    = KIND_DROP;
        end else begin
            r.kind    = KIND_DATA;
            r.data    = b;
            r.pos     = dec_count;
            dec_count = dec_count + 1'b1;
        end
        if (hit)
            pending_decodes.push_back(r);
    endfunction

    function automatic int draw_wait(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // Offer one byte and hold it until the block takes it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_wait(tx_run_left);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        decode_rx_byte(b);
        bytes_sent++;
    endtask

    // Hold the sender until every expected result is out, then let the pipeline settle
    task automatic drain;
        s_valid <= 1'b0;
        while (pending_decodes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_START_CODE:    code_start = val;
            CFG_END_CODE:      code_end   = val;
            CFG_ESCAPE_CODE:   code_esc   = val;
            CFG_UNESCAPE_MASK: code_mask  = val;
            default: ;
        endcase
    endtask

    // Only called with the block idle, by the caller's rule; drain() empties results only
    task automatic program_codes(input logic [BYTE_W-1:0] st, input logic [BYTE_W-1:0] en,
                                 input logic [BYTE_W-1:0] esc, input logic [BYTE_W-1:0] msk);
        drain();
        cfg_write(CFG_START_CODE, st);
        cfg_write(CFG_END_CODE, en);
        cfg_write(CFG_ESCAPE_CODE, esc);
        cfg_write(CFG_UNESCAPE_MASK, msk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Random byte, leaning towards the live codes
    function automatic logic [BYTE_W-1:0] pick_byte;
        case ($urandom_range(0, 7))
            0:       return code_start;
            1:       return code_end;
            2:       return code_esc;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One frame of the given length; a broken frame may have one byte swapped for a stray one
    task automatic send_frame(input int len, input bit broken);
        int                bad_at;
        int                i;
        logic [BYTE_W-1:0] v;
        bad_at = broken ? int'($urandom_range(0, len + 1)) : -1;
        send_byte(code_start);
        send_byte(len[BYTE_W-1:0]);
        for (i = 0; i <= len; i++) begin
            if (i == bad_at) begin
                send_byte(pick_byte());
            end else if (i == len) begin
                send_byte(code_end);
            end else begin
                v = BYTE_W'($urandom_range(0, 255));
                // stuff anything that would read as a code, and a few others besides
                if (v == code_start || v == code_end || v == code_esc ||
                    $urandom_range(0, 7) == 0)
                    send_byte(code_esc);
                send_byte(v);
            end
        end
    endtask

    task automatic test_directed_cases;
        // pass-through extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        // clean frame with an escaped all-ones byte
        send_byte(code_start); send_byte(8'd3);
        send_byte(8'h00); send_byte(code_esc); send_byte(8'hFF); send_byte(8'h55);
        send_byte(code_end);
        // zero length completes on the end code
        send_byte(code_start); send_byte(8'd0); send_byte(code_end);
        // count reached: an escape code drops the frame
        send_byte(code_start); send_byte(8'd0); send_byte(code_esc);
        // raw start mid-body drops and reopens
        send_byte(code_start); send_byte(8'd5); send_byte(8'h01); send_byte(code_start);
        send_byte(8'd0); send_byte(code_end);
        // raw end mid-body drops
        send_byte(code_start); send_byte(8'd4); send_byte(code_end);
    endtask

    // Mostly well-formed frames, some broken ones, some line noise
    task automatic test_random_traffic(input int budget, input int max_len);
        int first;
        int i;
        int sel;
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                send_frame($urandom_range(0, max_len), 1'b0);
            end else if (sel < 9) begin
                send_frame($urandom_range(0, max_len), 1'b1);
            end else begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    send_byte(pick_byte());
            end
            if ($urandom_range(0, 39) == 0)
                drain();
        end
    endtask

    task automatic test_code_settings;
        int k;
        // extremes
        program_codes(8'h00, 8'hFF, 8'h7E, 8'hFF);
        test_random_traffic(300, 12);
        program_codes(8'hFF, 8'h00, 8'h01, 8'h00);
        test_random_traffic(300, 12);
        // escape shares a value with the start code
        program_codes(8'h10, 8'h20, 8'h10, 8'h5A);
        test_random_traffic(250, 12);
        // arbitrary codes, coincidences allowed
        for (k = 0; k < 4; k++) begin
            program_codes(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                          BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            test_random_traffic(75, 20);
        end
    endtask

    // Longest frame reaches the top payload position
    task automatic test_long_frame;
        program_codes(8'hBA, 8'hDA, 8'hFA, 8'hA5);
        send_frame(255, 1'b0);
    endtask

    // Receiver: stall a random number of cycles before each result
    initial begin
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = draw_wait(rx_run_left);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Scoreboard: compare each result transaction with the oldest expectation
    initial begin
        decoded_t want;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                if (pending_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: kind %0d data %02h pos %0d len %0d",
                                 m_kind, m_data_byte, m_position, m_frame_length);
                end else begin
                    want = pending_decodes.pop_front();
                    if (m_kind !== want.kind || m_data_byte !== want.data ||
                        m_position !== want.pos || m_frame_length !== want.len) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result differs: expected kind %0d data %02h ",
                                      "pos %0d len %0d, got kind %0d data %02h ",
                                      "pos %0d len %0d"},
                                     want.kind, want.data, want.pos, want.len,
                                     m_kind, m_data_byte, m_position, m_frame_length);
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin
        code_start = START_CODE_RST;
        code_end   = END_CODE_RST;
        code_esc   = ESCAPE_CODE_RST;
        code_mask  = UNESCAPE_MASK_RST;
        dec_phase  = PHASE_IDLE;
        dec_count  = '0;
        dec_len    = '0;
        dec_esc    = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_directed_cases();
        test_code_settings();
        test_long_frame();

        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[stuffed_frame_receiver.f]
hw/rtl/sfr_pkg.sv
hw/rtl/stuffed_frame_receiver.sv
hw/rtl/stuffed_frame_receiver_checker.sv
dv/tb_stuffed_frame_receiver.sv
